### hw/rtl/vdia_pkg.sv
// vdia_pkg: shared types and constants for the vertex dedup index assign block
// no dependencies; imported by the controller, datapath and top level
`timescale 1ns / 1ps

package vdia_pkg;

   localparam int KEY_W     = 96;
   localparam int COORD_W   = 32;
   localparam int IDX_OUT_W = 8;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } vdia_state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } vdia_cmd_type;

   typedef struct packed {
      logic hit;
      logic exhausted;
      logic out_free;
   } vdia_stat_type;

endpackage

### hw/rtl/vdia_ctrl.sv
// vdia_ctrl: controller state machine for the vertex dedup block
// depends on vdia_pkg; drives the datapath through command and status structs
`timescale 1ns / 1ps

module vdia_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  vdia_pkg::vdia_stat_type stat_i,
   output vdia_pkg::vdia_cmd_type  cmd_o
);
   import vdia_pkg::*;

   vdia_state_type state_ff;
   vdia_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd_o      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_o.load = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat_i.hit || stat_i.exhausted) begin
               if (stat_i.out_free) begin
                  cmd_o.commit = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd_o.scan = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/vdia_dpath.sv
// vdia_dpath: key memory, scan pointer, compare and result register
// depends on vdia_pkg; sequenced by vdia_ctrl
`timescale 1ns / 1ps

module vdia_dpath #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  vdia_pkg::vdia_cmd_type             cmd_i,
   output vdia_pkg::vdia_stat_type            stat_o,
   input  logic                              req_start_of_mesh,
   input  logic [vdia_pkg::COORD_W-1:0]      req_pos_x_bits,
   input  logic [vdia_pkg::COORD_W-1:0]      req_pos_y_bits,
   input  logic [vdia_pkg::COORD_W-1:0]      req_pos_z_bits,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [vdia_pkg::IDX_OUT_W-1:0]    rsp_vertex_index,
   output logic                              rsp_is_new,
   output logic                              rsp_overflow
);
   import vdia_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

   logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];

   logic [KEY_W-1:0]     key_ff;
   logic [KEY_W-1:0]     rd_data_ff;
   logic [CNT_W-1:0]     count_ff,  count_in;
   logic [CNT_W-1:0]     ptr_ff,    ptr_in;
   logic [IDX_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic                 cmp_valid_ff, cmp_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_OUT_W-1:0] rsp_index_ff, rsp_index_in;
   logic                 rsp_new_ff,   rsp_new_in;
   logic                 rsp_ovf_ff,   rsp_ovf_in;

   logic             issue;
   logic             hit;
   logic             full;
   logic             insert;
   logic [CNT_W-1:0] res_idx;

   assign hit    = cmp_valid_ff && (rd_data_ff == key_ff);
   assign full   = (count_ff == FULL_COUNT);
   assign issue  = cmd_i.scan && (ptr_ff < count_ff);
   assign insert = cmd_i.commit && !hit && !full;

   assign stat_o.hit       = hit;
   assign stat_o.exhausted = !cmp_valid_ff && (ptr_ff == count_ff);
   assign stat_o.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_valid_in = cmp_valid_ff;
      if (cmd_i.load) begin
         if (req_start_of_mesh) begin
            count_in = '0;
         end
         ptr_in       = '0;
         cmp_valid_in = 1'b0;
      end else if (cmd_i.scan) begin
         cmp_valid_in = issue;
         if (issue) begin
            cmp_idx_in = ptr_ff[IDX_W-1:0];
            ptr_in     = ptr_ff + CNT_W'(1);
         end
      end else if (insert) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // result word
   always_comb begin
      if (hit) begin
         res_idx = CNT_W'(cmp_idx_ff);
      end else if (full) begin
         res_idx = '0;
      end else begin
         res_idx = count_ff;
      end
      rsp_index_in = IDX_OUT_W'(res_idx);
      rsp_new_in   = !hit && !full;
      rsp_ovf_in   = !hit && full;
      if (cmd_i.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      cmp_idx_ff <= cmp_idx_in;
      if (cmd_i.load) begin
         key_ff <= {req_pos_x_bits, req_pos_y_bits, req_pos_z_bits};
      end
      if (cmd_i.commit) begin
         rsp_index_ff <= rsp_index_in;
         rsp_new_ff   <= rsp_new_in;
         rsp_ovf_ff   <= rsp_ovf_in;
      end
   end

   // key memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (insert) begin
         key_mem[count_ff[IDX_W-1:0]] <= key_ff;
      end
      if (issue) begin
         rd_data_ff <= key_mem[ptr_ff[IDX_W-1:0]];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_index = rsp_index_ff;
   assign rsp_is_new       = rsp_new_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond table size");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd_i.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result word overwritten");

   a_new_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_new_ff && rsp_ovf_ff))
      else $error("new and overflow both set");

   a_insert_grow: assert property (@(posedge clock) disable iff (reset)
      insert |=> (count_ff == CNT_W'($past(count_ff) + CNT_W'(1))))
      else $error("insert did not grow table");

endmodule

### hw/rtl/vertex_dedup_index_assign_core.sv
// vertex_dedup_index_assign_core: top level of the vertex dedup block
// depends on vdia_pkg, vdia_ctrl and vdia_dpath
`timescale 1ns / 1ps

// Assigns compact indices to vertex positions in order of first appearance,
// matching exact 96-bit patterns against a key memory of TABLE_ENTRIES
// entries. One word is taken at a time; the key memory is read one entry per
// cycle, so a position found at entry i returns its result once entries 0 to
// i are read, while a position not in the table returns once all stored
// entries are read (with no read when the table is empty); either way the
// next word is taken once the result is committed. A result waiting on
// rsp_ready does not block acceptance of the next word. start_of_mesh empties
// the table at once; no clearing pass.
module vertex_dedup_index_assign_core #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_start_of_mesh,
   input  logic [vdia_pkg::COORD_W-1:0]   req_pos_x_bits,
   input  logic [vdia_pkg::COORD_W-1:0]   req_pos_y_bits,
   input  logic [vdia_pkg::COORD_W-1:0]   req_pos_z_bits,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [vdia_pkg::IDX_OUT_W-1:0] rsp_vertex_index,
   output logic                           rsp_is_new,
   output logic                           rsp_overflow
);
   import vdia_pkg::*;

   vdia_cmd_type  cmd;
   vdia_stat_type stat;

   vdia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat_i    (stat),
      .cmd_o     (cmd)
   );

   vdia_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd_i             (cmd),
      .stat_o            (stat),
      .req_start_of_mesh (req_start_of_mesh),
      .req_pos_x_bits    (req_pos_x_bits),
      .req_pos_y_bits    (req_pos_y_bits),
      .req_pos_z_bits    (req_pos_z_bits),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_vertex_index  (rsp_vertex_index),
      .rsp_is_new        (rsp_is_new),
      .rsp_overflow      (rsp_overflow)
   );

endmodule

### tb/sv/tb_top.sv
// tb_top: self-checking testbench for vertex_dedup_index_assign_core
// depends on vdia_pkg and the core; checks every word against a local key table
`timescale 1ns / 1ps

module tb_top;
   import vdia_pkg::*;

   localparam int TABLE_ENTRIES  = 256;
   localparam int TARGET_WORDS   = 1250;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = TABLE_ENTRIES + 60;

   typedef logic [KEY_W-1:0] vertex_key_type;

   typedef struct {
      logic           start_of_mesh;
      vertex_key_type key;
      logic           wait_for_drain;
   } vertex_word_type;

   typedef struct {
      logic [IDX_OUT_W-1:0] vertex_index;
      logic                 is_new;
      logic                 overflow;
   } index_result_type;

   logic                 clock             = 1'b0;
   logic                 reset             = 1'b1;
   logic                 req_valid         = 1'b0;
   logic                 req_ready;
   logic                 req_start_of_mesh = 1'b0;
   logic [COORD_W-1:0]   req_pos_x_bits    = '0;
   logic [COORD_W-1:0]   req_pos_y_bits    = '0;
   logic [COORD_W-1:0]   req_pos_z_bits    = '0;
   logic                 rsp_valid;
   logic                 rsp_ready         = 1'b0;
   logic [IDX_OUT_W-1:0] rsp_vertex_index;
   logic                 rsp_is_new;
   logic                 rsp_overflow;

   vertex_word_type  pending_words[$];
   index_result_type expected_index_q[$];
   vertex_key_type   mesh_keys[TABLE_ENTRIES];
   int               mesh_count   = 0;
   int               words_sent   = 0;
   int               results_seen = 0;
   int               fail_count   = 0;
   int               idle_cycles  = 0;
   int               send_idle_pct;
   int               recv_idle_pct;

   vertex_dedup_index_assign_core #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_start_of_mesh(req_start_of_mesh),
      .req_pos_x_bits   (req_pos_x_bits),
      .req_pos_y_bits   (req_pos_y_bits),
      .req_pos_z_bits   (req_pos_z_bits),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_is_new       (rsp_is_new),
      .rsp_overflow     (rsp_overflow)
   );

   always #10 clock = ~clock;

   // index of a position in the current mesh, storing it when first seen
   function automatic index_result_type assign_vertex_index(logic start, vertex_key_type key);
      index_result_type res;
      int slot;
      int i;
      res.vertex_index = '0;
      res.is_new       = 1'b0;
      res.overflow     = 1'b0;
      slot             = -1;
      if (start) begin
         mesh_count = 0;
      end
      for (i = 0; i < mesh_count; i++) begin
         if (slot < 0 && mesh_keys[i] == key) begin
            slot = i;
         end
      end
      if (slot >= 0) begin
         res.vertex_index = IDX_OUT_W'(slot);
      end else if (mesh_count < TABLE_ENTRIES) begin
         mesh_keys[mesh_count] = key;
         res.vertex_index      = IDX_OUT_W'(mesh_count);
         res.is_new            = 1'b1;
         mesh_count++;
      end else begin
         res.overflow = 1'b1;
      end
      return res;
   endfunction

   function automatic vertex_key_type random_key();
      return {$urandom, $urandom, $urandom};
   endfunction

   function automatic vertex_key_type near_miss(vertex_key_type key);
      return key ^ (vertex_key_type'(1) << $urandom_range(0, KEY_W - 1));
   endfunction

   // signed zeros, a quiet nan and all ones
   function automatic vertex_key_type special_key();
      case ($urandom_range(0, 3))
         0: return {3{32'h0000_0000}};
         1: return {32'h8000_0000, 32'h0000_0000, 32'h8000_0000};
         2: return {3{32'h7fc0_0000}};
         default: return {3{32'hffff_ffff}};
      endcase
   endfunction

   task automatic queue_vertex(logic start, vertex_key_type key, logic drain);
      vertex_word_type w;
      w.start_of_mesh  = start;
      w.key            = key;
      w.wait_for_drain = drain;
      pending_words = {pending_words, w};
   endtask

   // short mesh with repeats, near misses and special patterns
   task automatic queue_small_mesh();
      vertex_key_type pool[$];
      vertex_key_type key;
      int             length;
      int             pick;
      int             n;
      length = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      for (n = 0; n < length; n++) begin
         pick = $urandom_range(0, 99);
         if (pool.size() == 0 || pick < 30) begin
            key = random_key();
            pool = {pool, key};
         end else if (pick < 75) begin
            key = pool[$urandom_range(0, pool.size() - 1)];
         end else if (pick < 90) begin
            key = near_miss(pool[$urandom_range(0, pool.size() - 1)]);
            pool = {pool, key};
         end else begin
            key = special_key();
            pool = {pool, key};
         end
         queue_vertex(n == 0 && $urandom_range(0, 9) != 0, key, $urandom_range(0, 99) == 0);
      end
   endtask

   // fills every entry, then hits and misses against the full table
   task automatic queue_full_mesh();
      vertex_key_type fill_keys[$];
      int             n;
      for (n = 0; n < TABLE_ENTRIES; n++) begin
         fill_keys = {fill_keys, random_key()};
         queue_vertex(n == 0, fill_keys[n], n == 0);
         if ($urandom_range(0, 15) == 0) begin
            queue_vertex(1'b0, fill_keys[$urandom_range(0, n)], 1'b0);
         end
      end
      for (n = 0; n < 12; n++) begin
         case (n % 4)
            0: queue_vertex(1'b0, random_key(), 1'b0);
            1: queue_vertex(1'b0, fill_keys[TABLE_ENTRIES - 1], 1'b0);
            2: queue_vertex(1'b0, near_miss(fill_keys[$urandom_range(0, TABLE_ENTRIES - 1)]), 1'b0);
            default: queue_vertex(1'b0, fill_keys[$urandom_range(0, TABLE_ENTRIES - 1)], 1'b0);
         endcase
      end
      queue_vertex(1'b0, fill_keys[0], 1'b0);
   endtask

   always_comb begin
      if (words_sent < TARGET_WORDS / 3) begin
         send_idle_pct = 36;
         recv_idle_pct = 87;
      end else if (words_sent < 2 * TARGET_WORDS / 3) begin
         send_idle_pct = 87;
         recv_idle_pct = 36;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   end

   // driver, with the predictor run on each accepted word
   always @(posedge clock) begin
      vertex_word_type word;
      int              outstanding;
      outstanding = words_sent - results_seen - ((rsp_valid && rsp_ready) ? 1 : 0);
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_index_q = {expected_index_q, assign_vertex_index(req_start_of_mesh,
               {req_pos_x_bits, req_pos_y_bits, req_pos_z_bits})};
            words_sent <= words_sent + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
                !(pending_words[0].wait_for_drain && (req_valid || outstanding != 0))) begin
               word = pending_words.pop_front();
               req_valid         <= 1'b1;
               req_start_of_mesh <= word.start_of_mesh;
               {req_pos_x_bits, req_pos_y_bits, req_pos_z_bits} <= word.key;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      index_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (results_seen >= words_sent) begin
               $display("%0t unexpected word: expected none, actual index %0d new %0b ovf %0b",
                        $time, rsp_vertex_index, rsp_is_new, rsp_overflow);
               fail_count++;
            end else begin
               want = expected_index_q.pop_front();
               results_seen <= results_seen + 1;
               if (rsp_vertex_index !== want.vertex_index) begin
                  $display("%0t vertex_index mismatch: expected %0d, actual %0d",
                           $time, want.vertex_index, rsp_vertex_index);
                  fail_count++;
               end
               if (rsp_is_new !== want.is_new) begin
                  $display("%0t is_new mismatch: expected %0b, actual %0b",
                           $time, want.is_new, rsp_is_new);
                  fail_count++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $display("%0t overflow mismatch: expected %0b, actual %0b",
                           $time, want.overflow, rsp_overflow);
                  fail_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      bit second_fill_done;
      second_fill_done = 1'b0;

      // directed words
      queue_vertex(1'b1, {32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0);
      queue_vertex(1'b0, {32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}, 1'b0);
      queue_vertex(1'b0, {32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0);
      queue_vertex(1'b0, {32'h8000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0);
      queue_vertex(1'b0, {32'h0000_0000, 32'h8000_0000, 32'h0000_0000}, 1'b0);
      queue_vertex(1'b0, {32'h0000_0000, 32'h0000_0000, 32'h8000_0000}, 1'b0);
      queue_vertex(1'b0, {32'h7fc0_0000, 32'h7fc0_0000, 32'h7fc0_0000}, 1'b0);
      queue_vertex(1'b0, {32'h7fc0_0000, 32'h7fc0_0000, 32'h7fc0_0000}, 1'b0);
      queue_vertex(1'b0, {32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}, 1'b0);
      queue_vertex(1'b0, {32'h3f80_0000, 32'h4000_0000, 32'h4040_0000}, 1'b0);
      queue_vertex(1'b0, {32'h3f80_0000, 32'h4000_0000, 32'h4040_0001}, 1'b0);
      queue_vertex(1'b0, {32'h3f80_0000, 32'h4000_0000, 32'h4040_0000}, 1'b0);
      queue_vertex(1'b1, {32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}, 1'b0);
      queue_vertex(1'b0, {32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0);
      queue_vertex(1'b1, {32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0);
      queue_vertex(1'b0, {32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1);
      queue_vertex(1'b0, {32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa}, 1'b0);
      queue_vertex(1'b0, {32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555}, 1'b0);
      queue_vertex(1'b0, {32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa}, 1'b0);
      queue_vertex(1'b0, {32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}, 1'b0);

      // table fill with overflow, then random meshes and a second table fill
      queue_full_mesh();
      while (pending_words.size() < TARGET_WORDS) begin
         if (!second_fill_done && pending_words.size() >= 700) begin
            queue_full_mesh();
            second_fill_done = 1'b1;
         end else begin
            queue_small_mesh();
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid || words_sent != results_seen) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_index_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/vdia_pkg.sv
hw/rtl/vdia_ctrl.sv
hw/rtl/vdia_dpath.sv
hw/rtl/vertex_dedup_index_assign_core.sv
tb/sv/tb_top.sv
